[rtl/ase_pkg.sv]
// Shared constants for the array store engine.
// Holds sizes, operation codes and status codes; depends on nothing.
`timescale 1ns / 1ps

package ase_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WORD_W = 32;
    localparam int OP_W   = 4;
    localparam int IDX_W  = 9;
    localparam int AMT_W  = 16;
    localparam int POS_W  = 8;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 4'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 4'd1;
    localparam logic [OP_W-1:0] OP_ROT_R  = 4'd2;
    localparam logic [OP_W-1:0] OP_ROT_L  = 4'd3;
    localparam logic [OP_W-1:0] OP_MIN    = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX    = 4'd5;
    localparam logic [OP_W-1:0] OP_SORT   = 4'd6;
    localparam logic [OP_W-1:0] OP_READ   = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd8;
    localparam logic [OP_W-1:0] OP_ZERO   = 4'd9;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic             start;
        logic [AMT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } div_rsp_t;

endpackage

[rtl/ase_ram.sv]
// Simple dual-port word memory, one write and one registered read per cycle.
// Uses ase_pkg for depth and word width.
`timescale 1ns / 1ps

module ase_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ase_pkg::ADDR_W-1:0] waddr,
    input  logic [ase_pkg::WORD_W-1:0] wdata,
    input  logic                       re,
    input  logic [ase_pkg::ADDR_W-1:0] raddr,
    output logic [ase_pkg::WORD_W-1:0] rdata
);

    logic [ase_pkg::WORD_W-1:0] mem [ase_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/ase_divider.sv]
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Uses ase_pkg for widths and the request and response structs.
`timescale 1ns / 1ps

module ase_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ase_pkg::div_req_t req,
    output ase_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(ase_pkg::AMT_W + 1);

    logic                        busy_reg, busy_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [ase_pkg::AMT_W-1:0]   quo_reg, quo_next;
    logic [ase_pkg::CNT_W-1:0]   den_reg, den_next;
    logic [ase_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic                        done_reg, done_next;
    logic [ase_pkg::CNT_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[ase_pkg::AMT_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so one subtract suffices.
            if (trial >= {1'b0, den_reg})
            begin
                trial = trial - {1'b0, den_reg};
            end
            rem_next = trial[ase_pkg::CNT_W-1:0];
            quo_next = {quo_reg[ase_pkg::AMT_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ase_pkg::AMT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

[rtl/array_store_engine_unit.sv]
// Top level of the array store engine: operation sequencer, element and scratch memories.
// Uses ase_pkg, ase_ram and ase_divider.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     operation, index, value, amount
// output    out_valid / out_ready   data, position, count, status
//
// One transaction at a time; a memory step reads, then writes or compares; zero only writes.
// Rotate first reduces the amount modulo the count in the remainder unit, then writes the
// rotated words into scratch memory and copies them back; sort is an insertion sort.
// Reset clears the live count and the handshake state; memory contents are undefined.
// A finished result waits in the output register while the next transaction is accepted.

module array_store_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ase_pkg::OP_W-1:0]    operation,
    input  logic [ase_pkg::IDX_W-1:0]   index,
    input  logic signed [ase_pkg::WORD_W-1:0] value,
    input  logic [ase_pkg::AMT_W-1:0]   amount,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [ase_pkg::WORD_W-1:0] data,
    output logic [ase_pkg::POS_W-1:0]   position,
    output logic [ase_pkg::CNT_W-1:0]   count,
    output logic [ase_pkg::ST_W-1:0]    status
);

    localparam int CW = ase_pkg::CNT_W;
    localparam int AW = ase_pkg::ADDR_W;
    localparam int WW = ase_pkg::WORD_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INS_RD  = 5'd1;
    localparam logic [4:0] S_INS_WR  = 5'd2;
    localparam logic [4:0] S_DEL_RD  = 5'd3;
    localparam logic [4:0] S_DEL_WR  = 5'd4;
    localparam logic [4:0] S_DIV     = 5'd5;
    localparam logic [4:0] S_ROT_RD  = 5'd6;
    localparam logic [4:0] S_ROT_WR  = 5'd7;
    localparam logic [4:0] S_CPY_RD  = 5'd8;
    localparam logic [4:0] S_CPY_WR  = 5'd9;
    localparam logic [4:0] S_SCAN_RD = 5'd10;
    localparam logic [4:0] S_SCAN_CM = 5'd11;
    localparam logic [4:0] S_SORT_RV = 5'd12;
    localparam logic [4:0] S_SORT_GV = 5'd13;
    localparam logic [4:0] S_SORT_RK = 5'd14;
    localparam logic [4:0] S_SORT_CM = 5'd15;
    localparam logic [4:0] S_READ_WT = 5'd16;
    localparam logic [4:0] S_ZERO    = 5'd17;
    localparam logic [4:0] S_FINISH  = 5'd18;

    logic [4:0]                  state_reg, state_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [ase_pkg::OP_W-1:0]    op_reg, op_next;
    logic [ase_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [WW-1:0]               val_reg, val_next;
    logic [CW-1:0]               i_reg, i_next;
    logic [CW-1:0]               j_reg, j_next;
    logic [CW-1:0]               k_reg, k_next;
    logic [WW-1:0]               v_reg, v_next;
    logic [WW-1:0]               res_data_reg, res_data_next;
    logic [ase_pkg::POS_W-1:0]   res_pos_reg, res_pos_next;
    logic [ase_pkg::ST_W-1:0]    res_st_reg, res_st_next;
    logic                        ov_reg, ov_next;
    logic [WW-1:0]               od_reg, od_next;
    logic [ase_pkg::POS_W-1:0]   op_pos_reg, op_pos_next;
    logic [CW-1:0]               oc_reg, oc_next;
    logic [ase_pkg::ST_W-1:0]    os_reg, os_next;

    logic           m_we, m_re, s_we, s_re;
    logic [AW-1:0]  m_waddr, m_raddr, s_waddr, s_raddr;
    logic [WW-1:0]  m_wdata, m_rdata, s_wdata, s_rdata;
    logic           right;
    logic           better;
    logic [CW-1:0]  j_inc;

    ase_pkg::div_req_t div_req;
    ase_pkg::div_rsp_t div_rsp;

    ase_ram u_main (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    ase_ram u_scratch (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    ase_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign right = (op_reg == ase_pkg::OP_ROT_R);
    assign j_inc = j_reg + 1'b1;
    assign better = (op_reg == ase_pkg::OP_MIN) ? ($signed(m_rdata) < $signed(v_reg))
                                                : ($signed(v_reg) < $signed(m_rdata));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        v_next        = v_reg;
        res_data_next = res_data_reg;
        res_pos_next  = res_pos_reg;
        res_st_next   = res_st_reg;
        ov_next       = ov_reg;
        od_next       = od_reg;
        op_pos_next   = op_pos_reg;
        oc_next       = oc_reg;
        os_next       = os_reg;
        m_we = 1'b0; m_waddr = '0; m_wdata = '0;
        m_re = 1'b0; m_raddr = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        s_re = 1'b0; s_raddr = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = cnt_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = operation;
                    idx_next      = index;
                    val_next      = value;
                    res_data_next = '0;
                    res_pos_next  = '0;
                    res_st_next   = ase_pkg::ST_OK;
                    state_next    = S_FINISH;
                    unique case (operation)
                        ase_pkg::OP_INSERT:
                        begin
                            if (cnt_reg == CW'(ase_pkg::DEPTH))
                                res_st_next = ase_pkg::ST_FULL;
                            else if (index > cnt_reg)
                                res_st_next = ase_pkg::ST_RANGE;
                            else
                            begin
                                i_next     = cnt_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ase_pkg::OP_DELETE:
                        begin
                            if (cnt_reg == '0)
                                res_st_next = ase_pkg::ST_EMPTY;
                            else if (index >= cnt_reg)
                                res_st_next = ase_pkg::ST_RANGE;
                            else
                            begin
                                i_next     = index;
                                state_next = S_DEL_RD;
                            end
                        end
                        ase_pkg::OP_ROT_R, ase_pkg::OP_ROT_L:
                        begin
                            if (cnt_reg == '0)
                                res_st_next = ase_pkg::ST_EMPTY;
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = amount;
                                state_next       = S_DIV;
                            end
                        end
                        ase_pkg::OP_MIN, ase_pkg::OP_MAX:
                        begin
                            if (cnt_reg == '0)
                                res_st_next = ase_pkg::ST_EMPTY;
                            else
                            begin
                                i_next     = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        ase_pkg::OP_SORT:
                        begin
                            i_next     = CW'(1);
                            state_next = S_SORT_RV;
                        end
                        ase_pkg::OP_READ:
                        begin
                            if (cnt_reg == '0)
                                res_st_next = ase_pkg::ST_EMPTY;
                            else if (index >= cnt_reg)
                                res_st_next = ase_pkg::ST_RANGE;
                            else
                            begin
                                m_re       = 1'b1;
                                m_raddr    = index[AW-1:0];
                                state_next = S_READ_WT;
                            end
                        end
                        ase_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        ase_pkg::OP_ZERO:
                        begin
                            i_next     = '0;
                            state_next = S_ZERO;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (i_reg > idx_reg)
                begin
                    m_re       = 1'b1;
                    m_raddr    = AW'(i_reg - 1'b1);
                    state_next = S_INS_WR;
                end
                else
                begin
                    m_we       = 1'b1;
                    m_waddr    = idx_reg[AW-1:0];
                    m_wdata    = val_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_INS_WR:
            begin
                m_we       = 1'b1;
                m_waddr    = i_reg[AW-1:0];
                m_wdata    = m_rdata;
                i_next     = i_reg - 1'b1;
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                if (CW'(i_reg + 1'b1) < cnt_reg)
                begin
                    m_re       = 1'b1;
                    m_raddr    = AW'(i_reg + 1'b1);
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DEL_WR:
            begin
                m_we       = 1'b1;
                m_waddr    = i_reg[AW-1:0];
                m_wdata    = m_rdata;
                i_next     = i_reg + 1'b1;
                state_next = S_DEL_RD;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    i_next     = '0;
                    j_next     = div_rsp.remainder;
                    state_next = S_ROT_RD;
                end
            end
            S_ROT_RD:
            begin
                if (i_reg < cnt_reg)
                begin
                    m_re       = 1'b1;
                    m_raddr    = right ? i_reg[AW-1:0] : j_reg[AW-1:0];
                    state_next = S_ROT_WR;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_CPY_RD;
                end
            end
            S_ROT_WR:
            begin
                // Right rotation scatters by the moving index, left rotation gathers by it.
                s_we       = 1'b1;
                s_waddr    = right ? j_reg[AW-1:0] : i_reg[AW-1:0];
                s_wdata    = m_rdata;
                i_next     = i_reg + 1'b1;
                j_next     = (j_inc == cnt_reg) ? '0 : j_inc;
                state_next = S_ROT_RD;
            end
            S_CPY_RD:
            begin
                if (i_reg < cnt_reg)
                begin
                    s_re       = 1'b1;
                    s_raddr    = i_reg[AW-1:0];
                    state_next = S_CPY_WR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CPY_WR:
            begin
                m_we       = 1'b1;
                m_waddr    = i_reg[AW-1:0];
                m_wdata    = s_rdata;
                i_next     = i_reg + 1'b1;
                state_next = S_CPY_RD;
            end
            S_SCAN_RD:
            begin
                if (i_reg < cnt_reg)
                begin
                    m_re       = 1'b1;
                    m_raddr    = i_reg[AW-1:0];
                    state_next = S_SCAN_CM;
                end
                else
                begin
                    res_data_next = v_reg;
                    state_next    = S_FINISH;
                end
            end
            S_SCAN_CM:
            begin
                // Strict comparison keeps the first position of a tie.
                if (i_reg == '0 || better)
                begin
                    v_next       = m_rdata;
                    res_pos_next = i_reg[ase_pkg::POS_W-1:0];
                end
                i_next     = i_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_SORT_RV:
            begin
                if (i_reg < cnt_reg)
                begin
                    m_re       = 1'b1;
                    m_raddr    = i_reg[AW-1:0];
                    state_next = S_SORT_GV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SORT_GV:
            begin
                v_next     = m_rdata;
                k_next     = i_reg;
                state_next = S_SORT_RK;
            end
            S_SORT_RK:
            begin
                if (k_reg != '0)
                begin
                    m_re       = 1'b1;
                    m_raddr    = AW'(k_reg - 1'b1);
                    state_next = S_SORT_CM;
                end
                else
                begin
                    m_we       = 1'b1;
                    m_waddr    = '0;
                    m_wdata    = v_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_RV;
                end
            end
            S_SORT_CM:
            begin
                m_we    = 1'b1;
                m_waddr = k_reg[AW-1:0];
                if ($signed(v_reg) < $signed(m_rdata))
                begin
                    m_wdata    = m_rdata;
                    k_next     = k_reg - 1'b1;
                    state_next = S_SORT_RK;
                end
                else
                begin
                    m_wdata    = v_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_RV;
                end
            end
            S_READ_WT:
            begin
                res_data_next = m_rdata;
                state_next    = S_FINISH;
            end
            S_ZERO:
            begin
                if (i_reg < cnt_reg)
                begin
                    m_we    = 1'b1;
                    m_waddr = i_reg[AW-1:0];
                    m_wdata = '0;
                    i_next  = i_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    od_next     = res_data_reg;
                    op_pos_next = res_pos_reg;
                    oc_next     = cnt_reg;
                    os_next     = res_st_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        v_reg        <= v_next;
        res_data_reg <= res_data_next;
        res_pos_reg  <= res_pos_next;
        res_st_reg   <= res_st_next;
        od_reg       <= od_next;
        op_pos_reg   <= op_pos_next;
        oc_reg       <= oc_next;
        os_reg       <= os_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign data      = od_reg;
    assign position  = op_pos_reg;
    assign count     = oc_reg;
    assign status    = os_reg;

endmodule
